// ----- rtl/cm6sd_pkg.sv -----
// ----------------------------------------------------------------------------
// cm6sd_pkg
// Shared types, character codes and the digit map of the cm6 decoder.
// ----------------------------------------------------------------------------
package cm6sd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned DigitW = 6;
  localparam int unsigned SampleW = 32;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned DigitMoreBit = 5;
  localparam int unsigned DigitSignBit = 4;

  localparam logic [CodeW-1:0] CharPlus    = 7'd43;
  localparam logic [CodeW-1:0] CharMinus   = 7'd45;
  localparam logic [CodeW-1:0] CharZero    = 7'd48;
  localparam logic [CodeW-1:0] CharNine    = 7'd57;
  localparam logic [CodeW-1:0] CharUpperA  = 7'd65;
  localparam logic [CodeW-1:0] CharUpperZ  = 7'd90;
  localparam logic [CodeW-1:0] CharLowerA  = 7'd97;
  localparam logic [CodeW-1:0] CharLowerZ  = 7'd122;

  localparam logic [CodeW-1:0] OffsetDigit = 7'd46;
  localparam logic [CodeW-1:0] OffsetUpper = 7'd53;
  localparam logic [CodeW-1:0] OffsetLower = 7'd59;

  typedef struct packed {
    logic              mapped;
    logic [DigitW-1:0] value;
  } digit_t;

  typedef struct packed {
    logic clear;
    logic has_value;
    logic negative;
  } diff_ctrl_t;

  localparam int unsigned CtrlW = $bits(diff_ctrl_t);

  function automatic digit_t char_to_digit(logic [CodeW-1:0] c);
    digit_t d;
    logic [CodeW-1:0] diff;
    d.mapped = 1'b1;
    diff = '0;
    if (c == CharPlus) begin
      diff = '0;
    end else if (c == CharMinus) begin
      diff = 7'd1;
    end else if (c >= CharZero && c <= CharNine) begin
      diff = c - OffsetDigit;
    end else if (c >= CharUpperA && c <= CharUpperZ) begin
      diff = c - OffsetUpper;
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      diff = c - OffsetLower;
    end else begin
      d.mapped = 1'b0;
    end
    d.value = diff[DigitW-1:0];
    return d;
  endfunction

endpackage

// ----- rtl/cm6sd_char_if.sv -----
// ----------------------------------------------------------------------------
// cm6sd_char_if
// Character channel: valid/ready handshake with one text character per item.
// ----------------------------------------------------------------------------
interface cm6sd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_message;

  modport source (output valid, output char_code, output start_of_message, input ready);
  modport sink   (input valid, input char_code, input start_of_message, output ready);
endinterface

// ----- rtl/cm6sd_sample_if.sv -----
// ----------------------------------------------------------------------------
// cm6sd_sample_if
// Sample channel: valid/ready handshake with one decoded sample per item.
// ----------------------------------------------------------------------------
interface cm6sd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

// ----- rtl/cm6sd_front.sv -----
// ----------------------------------------------------------------------------
// cm6sd_front
// Maps characters to digits, gathers sign and magnitude of each difference
// and queues completed differences and message clears.
// ----------------------------------------------------------------------------
module cm6sd_front #(
  parameter int unsigned AccWidth = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [cm6sd_pkg::CharW-1:0] char_code_i,
  input  logic                     start_of_message_i,
  input  logic                     queue_ready_i,
  output logic                     push_o,
  output cm6sd_pkg::diff_ctrl_t    push_ctrl_o,
  output logic [AccWidth-1:0]      push_mag_o
);
  import cm6sd_pkg::*;

  logic [AccWidth-1:0] partial_q, partial_d;
  logic                cont_q, cont_d;
  logic                neg_q, neg_d;

  logic                accept;
  digit_t              dig;
  logic [AccWidth-1:0] base_partial;
  logic                base_cont;
  logic                base_neg;
  logic                neg_sel;
  logic [AccWidth-1:0] sum;

  assign accept = in_valid_i & queue_ready_i;
  assign dig    = char_to_digit(char_code_i[CodeW-1:0]);

  always_comb begin
    base_partial = start_of_message_i ? '0 : partial_q;
    base_cont    = start_of_message_i ? 1'b0 : cont_q;
    base_neg     = start_of_message_i ? 1'b0 : neg_q;
    if (base_cont) begin
      neg_sel = base_neg;
      sum     = base_partial + AccWidth'(dig.value[DigitSignBit:0]);
    end else begin
      neg_sel = dig.value[DigitSignBit];
      sum     = base_partial + AccWidth'(dig.value[DigitSignBit-1:0]);
    end
  end

  always_comb begin
    partial_d             = partial_q;
    cont_d                = cont_q;
    neg_d                 = neg_q;
    push_o                = 1'b0;
    push_ctrl_o.clear     = start_of_message_i;
    push_ctrl_o.has_value = 1'b0;
    push_ctrl_o.negative  = neg_sel;
    push_mag_o            = sum;
    if (accept) begin
      partial_d = base_partial;
      cont_d    = base_cont;
      neg_d     = base_neg;
      push_o    = start_of_message_i;
      if (dig.mapped) begin
        neg_d = neg_sel;
        if (dig.value[DigitMoreBit]) begin
          partial_d = {sum[AccWidth-ShiftW-1:0], ShiftW'(0)};
          cont_d    = 1'b1;
        end else begin
          partial_d             = '0;
          cont_d                = 1'b0;
          push_o                = 1'b1;
          push_ctrl_o.has_value = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      cont_q    <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      partial_q <= partial_d;
      cont_q    <= cont_d;
      neg_q     <= neg_d;
    end
  end

endmodule

// ----- rtl/cm6sd_fifo.sv -----
// ----------------------------------------------------------------------------
// cm6sd_fifo
// Short register queue between the front and the back end.
// ----------------------------------------------------------------------------
module cm6sd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [Width-1:0] pop_data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/cm6sd_back.sv -----
// ----------------------------------------------------------------------------
// cm6sd_back
// Double integrator with output register; applies queued message clears.
// ----------------------------------------------------------------------------
module cm6sd_back #(
  parameter int unsigned AccWidth = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  cm6sd_pkg::diff_ctrl_t         q_ctrl_i,
  input  logic [AccWidth-1:0]           q_mag_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cm6sd_pkg::SampleW-1:0] sample_value_o
);
  import cm6sd_pkg::*;

  localparam int unsigned ExtW = (AccWidth > SampleW) ? AccWidth : SampleW;

  logic [AccWidth-1:0] first_q, first_d;
  logic [AccWidth-1:0] second_q, second_d;
  logic                out_valid_q, out_valid_d;
  logic [SampleW-1:0]  sample_q, sample_d;

  logic [AccWidth-1:0] first_base, second_base;
  logic [AccWidth-1:0] first_new, second_new;
  logic [ExtW-1:0]     second_ext;

  assign pop_o = q_valid_i & (~q_ctrl_i.has_value | ~out_valid_q | out_ready_i);

  always_comb begin
    first_base  = q_ctrl_i.clear ? '0 : first_q;
    second_base = q_ctrl_i.clear ? '0 : second_q;
    first_new   = q_ctrl_i.negative ? first_base - q_mag_i : first_base + q_mag_i;
    second_new  = second_base + first_new;
    second_ext  = ExtW'(signed'(second_new));
  end

  always_comb begin
    first_d     = first_q;
    second_d    = second_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (pop_o) begin
      if (q_ctrl_i.has_value) begin
        first_d     = first_new;
        second_d    = second_new;
        sample_d    = second_ext[SampleW-1:0];
        out_valid_d = 1'b1;
      end else begin
        first_d  = first_base;
        second_d = second_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '0;
      second_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      first_q     <= first_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;

endmodule

// ----- rtl/cm6_second_difference_decoder.sv -----
// ----------------------------------------------------------------------------
// cm6_second_difference_decoder
// Decodes cm6 text into samples by double integration of signed differences.
// A difference is queued; its sample is then registered at the output.
// Throughput: one character per cycle while the two-entry queue has room;
// it and the output register let input and output stall independently.
// Reset clears the digit gatherer, both integrators, the queue and the output.
// ----------------------------------------------------------------------------
module cm6_second_difference_decoder #(
  parameter int unsigned ACC_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cm6sd_char_if.sink     char_i,
  cm6sd_sample_if.source sample_o
);
  import cm6sd_pkg::*;

  localparam int unsigned EntryW = CtrlW + ACC_WIDTH;

  logic                 push;
  diff_ctrl_t           push_ctrl;
  logic [ACC_WIDTH-1:0] push_mag;
  logic                 q_ready;
  logic                 q_valid;
  logic                 pop;
  logic [EntryW-1:0]    q_data;
  diff_ctrl_t           q_ctrl;
  logic [ACC_WIDTH-1:0] q_mag;
  logic [SampleW-1:0]   sample_bits;
  digit_t               in_digit;

  assign char_i.ready = q_ready;

  cm6sd_front #(
    .AccWidth (ACC_WIDTH)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (char_i.valid),
    .char_code_i        (char_i.char_code),
    .start_of_message_i (char_i.start_of_message),
    .queue_ready_i      (q_ready),
    .push_o             (push),
    .push_ctrl_o        (push_ctrl),
    .push_mag_o         (push_mag)
  );

  cm6sd_fifo #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  ({push_ctrl, push_mag}),
    .push_ready_o (q_ready),
    .pop_i        (pop),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data)
  );

  assign q_ctrl = q_data[EntryW-1:ACC_WIDTH];
  assign q_mag  = q_data[ACC_WIDTH-1:0];

  cm6sd_back #(
    .AccWidth (ACC_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ctrl_i       (q_ctrl),
    .q_mag_i        (q_mag),
    .pop_o          (pop),
    .out_valid_o    (sample_o.valid),
    .out_ready_i    (sample_o.ready),
    .sample_value_o (sample_bits)
  );

  assign sample_o.sample_value = signed'(sample_bits);

  assign in_digit = char_to_digit(char_i.char_code[CodeW-1:0]);

  a_push_needs_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (char_i.valid && char_i.ready))
    else $error("queue written without an accepted item");

  a_skip_no_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_i.valid && char_i.ready && !in_digit.mapped && !char_i.start_of_message)
      |-> !push)
    else $error("skipped character produced a queue entry");

  a_out_from_queue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sample_o.valid) |-> $past(q_valid && q_ctrl.has_value))
    else $error("sample shown without a queued difference");

endmodule
